FILE: hdl/arabic_word_validity_checker_top_defines.svh
// Assertion helpers for the checker RTL.
`ifndef ARABIC_WORD_VALIDITY_CHECKER_TOP_DEFINES_SVH
`define ARABIC_WORD_VALIDITY_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWVC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("awvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWVC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("awvc: next-cycle check failed");

`endif

FILE: hdl/awvc_pkg.sv
package awvc_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_HAMZA        = 21'h000621;
    localparam logic [CP_W-1:0] CP_WAW_HAMZA    = 21'h000624;
    localparam logic [CP_W-1:0] CP_YEH_HAMZA    = 21'h000626;
    localparam logic [CP_W-1:0] CP_TEH_MARBUTA  = 21'h000629;
    localparam logic [CP_W-1:0] CP_TATWEEL      = 21'h000640;
    localparam logic [CP_W-1:0] CP_DOTLESS_YEH  = 21'h000649;
    localparam logic [CP_W-1:0] CP_YEH          = 21'h00064A;
    localparam logic [CP_W-1:0] CP_FATHATAN     = 21'h00064B;
    localparam logic [CP_W-1:0] CP_SHADDA       = 21'h000651;
    localparam logic [CP_W-1:0] CP_SUKUN        = 21'h000652;

    localparam logic [1:0] RUN_MAX = 2'd3;

    typedef struct packed {
        logic letter;
        logic mark;
        logic shadda;
        logic teh_marbuta;
        logic dotless_yeh;
        logic hamza_seat;
    } cp_class_t;

    typedef struct packed {
        logic      valid;
        logic      last;
        cp_class_t cls;
    } char_req_t;

endpackage

FILE: hdl/awvc_classify.sv
module awvc_classify
    import awvc_pkg::*;
(
    input  logic [CP_W-1:0] code_point,
    output cp_class_t       cls
);

    always_comb begin
        cls.letter       = (code_point >= CP_HAMZA) && (code_point <= CP_YEH)
                           && (code_point != CP_TATWEEL);
        cls.mark         = (code_point >= CP_FATHATAN) && (code_point <= CP_SUKUN);
        cls.shadda       = (code_point == CP_SHADDA);
        cls.teh_marbuta  = (code_point == CP_TEH_MARBUTA);
        cls.dotless_yeh  = (code_point == CP_DOTLESS_YEH);
        cls.hamza_seat   = (code_point == CP_WAW_HAMZA) || (code_point == CP_YEH_HAMZA);
    end

endmodule

FILE: hdl/awvc_word_check.sv
`include "arabic_word_validity_checker_top_defines.svh"

module awvc_word_check
    import awvc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  char_req_t req,
    output logic      consume,
    output logic      m_valid,
    input  logic      m_ready,
    output logic      word_valid
);

    logic       at_start_reg,  at_start_next;
    logic       prev_shadda_reg, prev_shadda_next;
    logic       prev_teh_reg,  prev_teh_next;
    logic [1:0] run_reg,       run_next;
    logic       rejected_reg,  rejected_next;
    logic       m_valid_reg,   m_valid_next;
    logic       word_valid_reg, word_valid_next;

    logic can_emit;
    logic bad;
    logic finish;

    assign can_emit = !m_valid_reg || m_ready;
    // A word's last character waits until the result slot is free.
    assign consume  = req.valid && (!req.last || can_emit);
    assign finish   = consume && req.last;

    always_comb begin
        bad = 1'b0;
        if (!req.cls.letter && !req.cls.mark)
            bad = 1'b1;
        if (at_start_reg && (req.cls.mark || req.cls.hamza_seat))
            bad = 1'b1;
        if (req.cls.shadda && prev_shadda_reg)
            bad = 1'b1;
        if (req.cls.teh_marbuta && prev_teh_reg)
            bad = 1'b1;
        // third mark in a row: run already at two or more
        if (req.cls.mark && run_reg[1])
            bad = 1'b1;
        if (!req.last && (req.cls.teh_marbuta || req.cls.dotless_yeh))
            bad = 1'b1;
    end

    always_comb begin
        at_start_next    = at_start_reg;
        prev_shadda_next = prev_shadda_reg;
        prev_teh_next    = prev_teh_reg;
        run_next         = run_reg;
        rejected_next    = rejected_reg;
        if (consume) begin
            if (req.last) begin
                at_start_next    = 1'b1;
                prev_shadda_next = 1'b0;
                prev_teh_next    = 1'b0;
                run_next         = 2'd0;
                rejected_next    = 1'b0;
            end else begin
                at_start_next    = 1'b0;
                prev_shadda_next = req.cls.shadda;
                prev_teh_next    = req.cls.teh_marbuta;
                rejected_next    = rejected_reg || bad;
                if (!req.cls.mark)
                    run_next = 2'd0;
                else if (run_reg != RUN_MAX)
                    run_next = run_reg + 2'd1;
            end
        end
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        word_valid_next = word_valid_reg;
        if (finish) begin
            m_valid_next    = 1'b1;
            word_valid_next = !(rejected_reg || bad);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg    <= 1'b1;
            prev_shadda_reg <= 1'b0;
            prev_teh_reg    <= 1'b0;
            run_reg         <= 2'd0;
            rejected_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            at_start_reg    <= at_start_next;
            prev_shadda_reg <= prev_shadda_next;
            prev_teh_reg    <= prev_teh_next;
            run_reg         <= run_next;
            rejected_reg    <= rejected_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_valid_reg <= word_valid_next;
    end

    assign m_valid    = m_valid_reg;
    assign word_valid = word_valid_reg;

    `AWVC_ASSERT_NEXT(a_clear_after_word, aclk, aresetn, finish, at_start_reg && (run_reg == 2'd0) && !rejected_reg)
    `AWVC_ASSERT_NEXT(a_mid_word_not_start, aclk, aresetn, consume && !req.last, !at_start_reg)
    `AWVC_ASSERT_NEXT(a_rejected_word_fails, aclk, aresetn, finish && rejected_reg, m_valid_reg && !word_valid_reg)
    `AWVC_ASSERT_NOW(a_no_last_over_full_slot, aclk, aresetn, m_valid_reg && !m_ready, !finish)

endmodule

FILE: hdl/arabic_word_validity_checker_top.sv
// Arabic word validity checker. Feed the code points of one word, one per
// request, with s_tlast set on the final character; after that character one
// result comes out on the m_ side with bit 0 of m_tdata set when the word is
// valid. Characters that are not last produce no result. The block takes one
// request per cycle while s_tready is high: each character is held in the
// input register, where it is classified and checked against the per-word
// flags, and a last character then loads the result register, which drives
// m_tvalid and m_tdata. Stalls on m_tready hold only a last character in the
// input register; the block returns to the word-start state after every word.
module arabic_word_validity_checker_top
    import awvc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] word_valid, [7:1] zero
);

    logic            in_valid_reg, in_valid_next;
    logic            in_last_reg,  in_last_next;
    logic [CP_W-1:0] in_cp_reg,    in_cp_next;

    cp_class_t cls;
    char_req_t req;
    logic      consume;
    logic      word_valid;

    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_last_next  = in_last_reg;
        in_cp_next    = in_cp_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_last_next  = s_tlast;
            in_cp_next    = s_tdata[CP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_last_reg <= in_last_next;
        in_cp_reg   <= in_cp_next;
    end

    awvc_classify u_classify (
        .code_point (in_cp_reg),
        .cls        (cls)
    );

    assign req.valid = in_valid_reg;
    assign req.last  = in_last_reg;
    assign req.cls   = cls;

    awvc_word_check u_word_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .consume    (consume),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .word_valid (word_valid)
    );

    assign m_tdata = {7'd0, word_valid};

endmodule

FILE: test/word_rule_checker.sv
module word_rule_checker
    import awvc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_tlast,   // last_char
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] word_valid, [7:1] zero
    output int          fail_count,
    output int          words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic       word_start;
    logic       after_shadda;
    logic       after_teh_marbuta;
    logic [1:0] mark_run;
    logic       word_failed;
    bit         word_valid_due[$];
    int         mismatches = 0;
    int         due_words = 0;

    assign fail_count    = mismatches;
    assign words_pending = due_words;

    task automatic clear_word_flags();
        word_start        = 1'b1;
        after_shadda      = 1'b0;
        after_teh_marbuta = 1'b0;
        mark_run          = 2'd0;
        word_failed       = 1'b0;
    endtask

    // Fold one character into the word flags; a last character queues the verdict.
    task automatic scan_code_point(input logic [CP_W-1:0] cp, input logic last);
        logic is_letter;
        logic is_mark;
        logic bad;
        is_letter = (cp >= CP_HAMZA) && (cp <= CP_YEH) && (cp != CP_TATWEEL);
        is_mark   = (cp >= CP_FATHATAN) && (cp <= CP_SUKUN);
        bad       = !is_letter && !is_mark;
        if (word_start && (is_mark || cp == CP_WAW_HAMZA || cp == CP_YEH_HAMZA))
            bad = 1'b1;
        if (cp == CP_SHADDA && after_shadda)
            bad = 1'b1;
        if (cp == CP_TEH_MARBUTA && after_teh_marbuta)
            bad = 1'b1;
        // a third mark in a row
        if (is_mark && mark_run >= 2'd2)
            bad = 1'b1;
        if (!last && (cp == CP_TEH_MARBUTA || cp == CP_DOTLESS_YEH))
            bad = 1'b1;

        if (last) begin
            word_valid_due.push_back(!(word_failed || bad));
            clear_word_flags();
        end else begin
            word_failed       = word_failed || bad;
            word_start        = 1'b0;
            after_shadda      = (cp == CP_SHADDA);
            after_teh_marbuta = (cp == CP_TEH_MARBUTA);
            if (!is_mark)
                mark_run = 2'd0;
            else if (mark_run != RUN_MAX)
                mark_run = mark_run + 2'd1;
        end
    endtask

    always @(posedge aclk) begin
        bit expected;
        if (!aresetn) begin
            clear_word_flags();
            word_valid_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (word_valid_due.size() == 0) begin
                    $error("word_valid: expected none, actual %0b", m_tdata[0]);
                    mismatches++;
                end else begin
                    expected = word_valid_due.pop_front();
                    if (m_tdata[0] !== expected) begin
                        $error("word_valid: expected %0b, actual %0b", expected, m_tdata[0]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                scan_code_point(s_tdata[CP_W-1:0], s_tlast);
        end
        due_words = word_valid_due.size();
    end

endmodule

FILE: test/tb_top.sv
module tb_top;
    import awvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1950;
    localparam int QUIET_LIMIT  = 4000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    int          fail_count;
    int          words_pending;

    logic [CP_W-1:0] char_q[$];
    bit              last_q[$];
    int              quiet_cycles = 0;

    arabic_word_validity_checker_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    word_rule_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic add_char(input logic [CP_W-1:0] cp, input bit last);
        char_q.push_back(cp);
        last_q.push_back(last);
    endtask

    function automatic logic [CP_W-1:0] pick_letter(input bit allow_final);
        logic [CP_W-1:0] c;
        do
            c = CP_W'($urandom_range(CP_HAMZA, CP_YEH));
        while (c == CP_TATWEEL ||
               (!allow_final && (c == CP_TEH_MARBUTA || c == CP_DOTLESS_YEH)));
        return c;
    endfunction

    // Characters near the rule boundaries.
    function automatic logic [CP_W-1:0] pick_tricky();
        case ($urandom_range(0, 11))
            0:       return CP_TEH_MARBUTA;
            1:       return CP_DOTLESS_YEH;
            2:       return CP_SHADDA;
            3:       return CP_WAW_HAMZA;
            4:       return CP_YEH_HAMZA;
            5:       return CP_TATWEEL;
            6:       return CP_HAMZA - 21'd1;
            7:       return CP_SUKUN + 21'd1;
            8:       return CP_HAMZA;
            9:       return CP_YEH;
            10:      return 21'h000020;
            default: return CP_W'($urandom_range(CP_FATHATAN, CP_SUKUN));
        endcase
    endfunction

    task automatic add_directed();
        add_char(CP_TEH_MARBUTA, 1'b1);
        add_char(CP_DOTLESS_YEH, 1'b1);
        add_char(21'h000000, 1'b1);
        add_char(21'h1FFFFF, 1'b1);
        add_char(21'h10FFFF, 1'b1);
        // adjacent shadda
        add_char(21'h000628, 1'b0); add_char(CP_SHADDA, 1'b0); add_char(CP_SHADDA, 1'b1);
        // adjacent teh marbuta
        add_char(21'h000628, 1'b0); add_char(CP_TEH_MARBUTA, 1'b0);
        add_char(CP_TEH_MARBUTA, 1'b1);
        // three marks closing the word
        add_char(21'h000628, 1'b0); add_char(21'h00064E, 1'b0);
        add_char(CP_SHADDA, 1'b0); add_char(21'h000650, 1'b1);
        add_char(CP_FATHATAN, 1'b1);
        add_char(CP_WAW_HAMZA, 1'b1);
        add_char(CP_YEH_HAMZA, 1'b1);
        add_char(21'h000628, 1'b0); add_char(21'h000020, 1'b1);
        add_char(21'h000628, 1'b0); add_char(CP_TATWEEL, 1'b1);
        add_char(21'h000627, 1'b0); add_char(21'h000644, 1'b0);
        add_char(21'h000628, 1'b0); add_char(21'h00064E, 1'b1);
    endtask

    task automatic add_clean_word();
        int  len;
        int  run;
        bit  last;
        logic [CP_W-1:0] c;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        run = 0;
        for (int pos = 0; pos < len; pos++) begin
            last = (pos == len - 1);
            if ($urandom_range(0, 11) == 0) begin
                c = pick_tricky();
            end else if (pos == 0) begin
                do
                    c = pick_letter(last);
                while (c == CP_WAW_HAMZA || c == CP_YEH_HAMZA);
            end else if (run < 2 && $urandom_range(0, 2) == 0) begin
                c = CP_W'($urandom_range(CP_FATHATAN, CP_SUKUN));
            end else begin
                c = pick_letter(last);
            end
            run = (c >= CP_FATHATAN && c <= CP_SUKUN) ? run + 1 : 0;
            add_char(c, last);
        end
    endtask

    task automatic add_noise_word();
        int len;
        logic [CP_W-1:0] c;
        len = $urandom_range(1, 6);
        for (int pos = 0; pos < len; pos++) begin
            case ($urandom_range(0, 3))
                0:       c = CP_W'($urandom);
                1:       c = pick_tricky();
                2:       c = CP_W'($urandom_range(CP_FATHATAN, CP_SUKUN));
                default: c = pick_letter(1'b1);
            endcase
            add_char(c, pos == len - 1);
        end
    endtask

    // Receiver: switch between steady, random, periodic and mostly stalled.
    always @(negedge aclk) begin
        int stall_mode;
        int mode_left;
        int phase;
        if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (phase % 5 != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int burst_left;
        int gap;
        int directed_count;
        add_directed();
        directed_count = char_q.size();
        while (char_q.size() < directed_count + RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7)
                add_clean_word();
            else
                add_noise_word();
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        burst_left = $urandom_range(1, 40);
        foreach (char_q[i]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    // drop valid and scramble the bus while idle
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    s_tdata  <= 24'($urandom);
                    s_tlast  <= 1'($urandom_range(0, 1));
                    repeat (gap - 1) @(negedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 40);
            end
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b000, char_q[i]};
            s_tlast  <= last_q[i];
            do
                @(posedge aclk);
            while (!(s_tvalid && s_tready));
            burst_left--;
        end
        @(negedge aclk) s_tvalid <= 1'b0;

        while (words_pending != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && words_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
